// ===== sv/header_length_checksum_packet_receiver_macros.svh =====
// ----------------------------------------------------------------------------
// header_length_checksum_packet_receiver_macros
// assertion macros for the packet receiver, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef HEADER_LENGTH_CHECKSUM_PACKET_RECEIVER_MACROS_SVH
`define HEADER_LENGTH_CHECKSUM_PACKET_RECEIVER_MACROS_SVH

`ifndef SYNTHESIS
// condition holds at every edge out of reset
`define HLCPR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// antecedent implies consequent on the next edge
`define HLCPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HLCPR_ASSERT_ALWAYS(label, cond, msg)
`define HLCPR_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== sv/hlcpr_pkg.sv =====
// ----------------------------------------------------------------------------
// hlcpr_pkg
// shared types and constants of the header/length/checksum packet receiver
// ----------------------------------------------------------------------------
`default_nettype none

package hlcpr_pkg;

  // framing constants
  localparam int MAX_PAYLOAD = 32;
  localparam int PAY_OFFSET  = 4;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int POS_W       = $clog2(MAX_PAYLOAD + PAY_OFFSET + 1);

  // configuration register indexes
  localparam logic REG_HEADER_FIRST  = 1'b0;
  localparam logic REG_HEADER_SECOND = 1'b1;

  // operation codes
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // result kinds
  localparam logic KIND_STATUS  = 1'b0;
  localparam logic KIND_READOUT = 1'b1;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_COMPLETE = 3'd1,
    EV_LINE     = 3'd2,
    EV_OVERRUN  = 3'd3,
    EV_CHECKSUM = 3'd4,
    EV_DROPPED  = 3'd5
  } ev_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_LINE     = 2'd1,
    ERR_OVERRUN  = 2'd2,
    ERR_CHECKSUM = 2'd3
  } err_t;

  // parser state seen by the output side
  typedef struct packed {
    logic             held;
    logic [7:0]       command;
    logic [LEN_W-1:0] length;
    err_t             sticky;
    logic [2:0]       line_bits;
    ev_t              event_code;
  } view_t;

  // payload store write request
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  // one result word
  typedef struct packed {
    logic              result_kind;
    ev_t               event_code;
    err_t              last_error;
    logic [2:0]        last_line_bits;
    logic [7:0]        command;
    logic [LEN_W-1:0]  payload_length;
    logic [7:0]        data_byte;
    logic [ADDR_W-1:0] byte_index;
    logic              last;
    logic              payload_valid;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/hlcpr_parser.sv =====
// ----------------------------------------------------------------------------
// hlcpr_parser
// byte framing: header hunt, length check, running checksum, hold and errors
// ----------------------------------------------------------------------------
`default_nettype none

module hlcpr_parser
  import hlcpr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       byte_go,
  input  wire logic       release_go,
  input  wire logic [7:0] rx_byte,
  input  wire logic [2:0] line_error_bits,
  output view_t           view,
  output wr_t             wr
);

  logic [7:0]       header_first;
  logic [7:0]       header_second;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]       running_sum, running_sum_next;
  logic             packet_held, packet_held_next;
  logic [7:0]       held_command, held_command_next;
  logic [LEN_W-1:0] held_length, held_length_next;
  err_t             sticky_error, sticky_error_next;
  logic [2:0]       line_bits, line_bits_next;
  ev_t              ev;
  logic [POS_W-1:0] end_position;
  logic [POS_W-1:0] store_position;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= 8'hAA;
      header_second <= 8'h55;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEADER_FIRST:  header_first  <= cfg_wdata;
        REG_HEADER_SECOND: header_second <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign end_position   = POS_W'(held_length) + POS_W'(PAY_OFFSET);
  assign store_position = byte_position - POS_W'(PAY_OFFSET);

  // framing step for one line byte, or a release of the held packet
  always_comb begin
    byte_position_next = byte_position;
    running_sum_next   = running_sum;
    packet_held_next   = packet_held;
    held_command_next  = held_command;
    held_length_next   = held_length;
    sticky_error_next  = sticky_error;
    line_bits_next     = line_bits;
    ev                 = EV_NONE;
    wr.en              = 1'b0;
    wr.addr            = store_position[ADDR_W-1:0];
    wr.data            = rx_byte;

    if (byte_go) begin
      if (packet_held) begin
        ev = EV_DROPPED;
      end else if (line_error_bits != 3'd0) begin
        sticky_error_next  = ERR_LINE;
        line_bits_next     = line_error_bits;
        byte_position_next = '0;
        running_sum_next   = '0;
        ev                 = EV_LINE;
      end else if (byte_position == POS_W'(0)) begin
        if (rx_byte == header_first) begin
          running_sum_next   = rx_byte;
          byte_position_next = POS_W'(1);
        end
      end else if (byte_position == POS_W'(1)) begin
        if (rx_byte != header_second) begin
          byte_position_next = '0;
          running_sum_next   = '0;
        end else begin
          running_sum_next   = running_sum + rx_byte;
          byte_position_next = byte_position + POS_W'(1);
        end
      end else if (byte_position == POS_W'(2)) begin
        held_command_next  = rx_byte;
        running_sum_next   = running_sum + rx_byte;
        byte_position_next = byte_position + POS_W'(1);
      end else if (byte_position == POS_W'(3)) begin
        if (rx_byte > 8'(MAX_PAYLOAD)) begin
          sticky_error_next  = ERR_OVERRUN;
          byte_position_next = '0;
          running_sum_next   = '0;
          ev                 = EV_OVERRUN;
        end else begin
          held_length_next   = rx_byte[LEN_W-1:0];
          running_sum_next   = running_sum + rx_byte;
          byte_position_next = byte_position + POS_W'(1);
        end
      end else if (byte_position == end_position) begin
        // checksum byte closes the frame
        if (rx_byte == running_sum) begin
          packet_held_next = 1'b1;
          ev               = EV_COMPLETE;
        end else begin
          sticky_error_next = ERR_CHECKSUM;
          ev                = EV_CHECKSUM;
        end
        byte_position_next = '0;
        running_sum_next   = '0;
      end else begin
        wr.en              = 1'b1;
        running_sum_next   = running_sum + rx_byte;
        byte_position_next = byte_position + POS_W'(1);
      end
    end else if (release_go) begin
      packet_held_next = 1'b0;
    end
  end

  // framing state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      running_sum   <= '0;
      packet_held   <= 1'b0;
      held_command  <= '0;
      held_length   <= '0;
      sticky_error  <= ERR_NONE;
      line_bits     <= '0;
    end else begin
      byte_position <= byte_position_next;
      running_sum   <= running_sum_next;
      packet_held   <= packet_held_next;
      held_command  <= held_command_next;
      held_length   <= held_length_next;
      sticky_error  <= sticky_error_next;
      line_bits     <= line_bits_next;
    end
  end

  // held packet as registered, error state after this byte
  assign view.held       = packet_held;
  assign view.command    = held_command;
  assign view.length     = held_length;
  assign view.sticky     = sticky_error_next;
  assign view.line_bits  = line_bits_next;
  assign view.event_code = ev;

endmodule

`default_nettype wire

// ===== sv/hlcpr_emitter.sv =====
// ----------------------------------------------------------------------------
// hlcpr_emitter
// payload store, readout sequencer and output register
// ----------------------------------------------------------------------------
`default_nettype none

module hlcpr_emitter
  import hlcpr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic accept,
  input  wire logic operation,
  input  view_t     view,
  input  wr_t       wr,
  input  wire logic out_ready,
  output logic      out_valid,
  output result_t   result,
  output logic      busy
);

  logic [7:0]        payload_store [MAX_PAYLOAD];
  logic [ADDR_W-1:0] read_index;
  logic [ADDR_W-1:0] emit_index;
  logic              emit_last;
  logic              out_free;
  logic              start;
  logic              step;
  logic              read_fire;
  logic              load;
  result_t           result_next;

  assign out_free  = !out_valid || out_ready;
  assign start     = accept && (operation == OP_RELEASE) && view.held &&
                     (view.length != '0);
  assign step      = busy && out_free;
  assign read_fire = start || step;
  assign load      = accept || step;

  assign emit_index = busy ? read_index : '0;
  assign emit_last  = (LEN_W'(emit_index) == view.length - LEN_W'(1));

  // result word without the payload byte
  always_comb begin
    result_next                = '0;
    result_next.last_error     = view.sticky;
    result_next.last_line_bits = view.line_bits;
    if (read_fire) begin
      result_next.result_kind    = KIND_READOUT;
      result_next.command        = view.command;
      result_next.payload_length = view.length;
      result_next.byte_index     = emit_index;
      result_next.last           = emit_last;
      result_next.payload_valid  = 1'b1;
    end else if (operation == OP_RELEASE) begin
      result_next.result_kind   = KIND_READOUT;
      result_next.last          = 1'b1;
      result_next.payload_valid = view.held;
      result_next.command       = view.held ? view.command : 8'd0;
    end else begin
      result_next.result_kind = KIND_STATUS;
      result_next.event_code  = view.event_code;
    end
  end

  // payload store write and registered read into the result
  always_ff @(posedge clk) begin : store_and_load
    result_t word;
    word           = result_next;
    word.data_byte = read_fire ? payload_store[emit_index] : 8'd0;
    if (wr.en) begin
      payload_store[wr.addr] <= wr.data;
    end
    if (load) begin
      result <= word;
    end
  end

  // readout sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      read_index <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (read_fire) begin
        busy       <= !emit_last;
        read_index <= emit_index + ADDR_W'(1);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/header_length_checksum_packet_receiver.sv =====
// ----------------------------------------------------------------------------
// header_length_checksum_packet_receiver
// frames header/command/length/payload/checksum packets and reads them out
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_axis    in         tvalid / tready    tdata: byte, line bits; tuser: op
//  m_axis    out        tvalid / tready    tdata: result; tuser: kind, valid
//  cfg       in         cfg_we             cfg_index, cfg_wdata
//
//  one result word per line byte, one word per cycle given m_tready; a release
//  of a packet with N bytes gives N words (one if N is 0), one per cycle given
//  m_tready, set by the single read port of the payload store; input is held
//  off meanwhile. the output register frees a slot in the cycle its word is
//  taken. rst is synchronous and clears framing state, headers go to AA and 55
// ----------------------------------------------------------------------------
`default_nettype none

`include "header_length_checksum_packet_receiver_macros.svh"

module header_length_checksum_packet_receiver
  import hlcpr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // rx_byte [7:0], line_error_bits [10:8], zero [15:11]
  input  wire logic [15:0] s_tdata,
  // operation [0]
  input  wire logic        s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // event_code [2:0], last_error [4:3], last_line_bits [7:5], command [15:8],
  // payload_length [21:16], data_byte [29:22], byte_index [34:30], zero [39:35]
  output logic [39:0]      m_tdata,
  // result_kind [0], payload_valid [1]
  output logic [1:0]       m_tuser,
  output logic             m_tlast
);

  logic    accept;
  logic    byte_go;
  logic    release_go;
  logic    busy;
  view_t   view;
  wr_t     wr;
  result_t result;

  // input handshake
  assign s_tready   = !busy && (!m_tvalid || m_tready);
  assign accept     = s_tvalid && s_tready;
  assign byte_go    = accept && (s_tuser == OP_BYTE);
  assign release_go = accept && (s_tuser == OP_RELEASE);

  hlcpr_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .byte_go         (byte_go),
    .release_go      (release_go),
    .rx_byte         (s_tdata[7:0]),
    .line_error_bits (s_tdata[10:8]),
    .view            (view),
    .wr              (wr)
  );

  hlcpr_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (s_tuser),
    .view      (view),
    .wr        (wr),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .result    (result),
    .busy      (busy)
  );

  // output packing
  assign m_tdata = {5'd0, result.byte_index, result.data_byte, result.payload_length,
                    result.command, result.last_line_bits, result.last_error,
                    result.event_code};
  assign m_tuser = {result.payload_valid, result.result_kind};
  assign m_tlast = result.last;

  // checks
  `HLCPR_ASSERT_ALWAYS(a_busy_blocks_input, !(busy && s_tready), "input taken during readout")
  `HLCPR_ASSERT_NEXT(a_long_release_runs, release_go && view.held && (view.length > LEN_W'(1)), busy, "readout did not start")
  `HLCPR_ASSERT_NEXT(a_held_byte_dropped, byte_go && view.held, m_tvalid && (m_tdata[2:0] == EV_DROPPED), "byte while held not dropped")
  `HLCPR_ASSERT_ALWAYS(a_status_no_last, !(m_tvalid && !m_tuser[0] && (m_tlast || m_tuser[1])), "status word marked as readout")

endmodule

`default_nettype wire

// ===== dv/tb_header_length_checksum_packet_receiver.sv =====
// ----------------------------------------------------------------------------
// tb_header_length_checksum_packet_receiver
// self-checking bench for the header/length/checksum packet receiver
// ----------------------------------------------------------------------------
//  a directed table walks the framing corner cases: line errors, header
//  mismatches, length overrun, bad and good checksums, bytes dropped while
//  a packet is held, and releases with and without a held packet. random
//  traffic then sends mostly well-formed packets with random content, mixed
//  with corrupted packets and line noise, under several header settings and
//  with random idling on both streams. every result word is checked field by
//  field against an in-bench model of the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_header_length_checksum_packet_receiver;
  import hlcpr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PRINT_LIMIT    = 50;

  // one result word, split into its fields
  typedef struct packed {
    logic              kind;
    ev_t               ev;
    err_t              err;
    logic [2:0]        line_bits;
    logic [7:0]        cmd;
    logic [LEN_W-1:0]  len;
    logic [7:0]        data;
    logic [ADDR_W-1:0] idx;
    logic              last;
    logic              valid;
  } rx_result_t;

  // one directed input word, with event and sticky error typed in where obvious
  typedef struct packed {
    logic       op;
    logic [7:0] rx;
    logic [2:0] lerr;
    logic       typed;
    ev_t        ev;
    err_t       err;
  } stim_row_t;

  // default headers AA 55 apply during this table
  localparam stim_row_t DIRECTED_ITEMS [21] = '{
    // release with nothing held, right after reset
    '{OP_RELEASE, 8'hFF, 3'd7, 1'b1, EV_NONE,     ERR_NONE},
    // line error with all status bits set
    '{OP_BYTE,    8'h00, 3'd7, 1'b1, EV_LINE,     ERR_LINE},
    // second header wrong, then that byte is not taken as a first header
    '{OP_BYTE,    8'hAA, 3'd0, 1'b0, EV_NONE,     ERR_NONE},
    '{OP_BYTE,    8'h00, 3'd0, 1'b0, EV_NONE,     ERR_NONE},
    '{OP_BYTE,    8'h55, 3'd0, 1'b0, EV_NONE,     ERR_NONE},
    // length one above the maximum
    '{OP_BYTE,    8'hAA, 3'd0, 1'b0, EV_NONE,     ERR_NONE},
    '{OP_BYTE,    8'h55, 3'd0, 1'b0, EV_NONE,     ERR_NONE},
    '{OP_BYTE,    8'h07, 3'd0, 1'b0, EV_NONE,     ERR_NONE},
    '{OP_BYTE,    8'h21, 3'd0, 1'b1, EV_OVERRUN,  ERR_OVERRUN},
    // empty packet with a bad checksum
    '{OP_BYTE,    8'hAA, 3'd0, 1'b0, EV_NONE,     ERR_NONE},
    '{OP_BYTE,    8'h55, 3'd0, 1'b0, EV_NONE,     ERR_NONE},
    '{OP_BYTE,    8'hFF, 3'd0, 1'b0, EV_NONE,     ERR_NONE},
    '{OP_BYTE,    8'h00, 3'd0, 1'b0, EV_NONE,     ERR_NONE},
    '{OP_BYTE,    8'h00, 3'd0, 1'b1, EV_CHECKSUM, ERR_CHECKSUM},
    // empty packet, good checksum, sticky error kept
    '{OP_BYTE,    8'hAA, 3'd0, 1'b0, EV_NONE,     ERR_NONE},
    '{OP_BYTE,    8'h55, 3'd0, 1'b0, EV_NONE,     ERR_NONE},
    '{OP_BYTE,    8'hFF, 3'd0, 1'b0, EV_NONE,     ERR_NONE},
    '{OP_BYTE,    8'h00, 3'd0, 1'b0, EV_NONE,     ERR_NONE},
    '{OP_BYTE,    8'hFE, 3'd0, 1'b1, EV_COMPLETE, ERR_CHECKSUM},
    // byte with a line error while held is dropped
    '{OP_BYTE,    8'hFF, 3'd5, 1'b1, EV_DROPPED,  ERR_CHECKSUM},
    // readout of the empty packet
    '{OP_RELEASE, 8'h00, 3'd0, 1'b1, EV_NONE,     ERR_CHECKSUM}
  };

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  // parser model state
  logic [7:0] hdr_first;
  logic [7:0] hdr_second;
  int         frame_pos;
  logic [7:0] frame_sum;
  logic       pkt_held;
  logic [7:0] pkt_cmd;
  logic [7:0] pkt_len;
  logic [7:0] pkt_bytes [MAX_PAYLOAD];
  err_t       sticky;
  logic [2:0] line_bits;

  rx_result_t burst [MAX_PAYLOAD];
  rx_result_t expected_words [$];

  int src_idle;
  int sink_stall;
  int sink_hold;
  int items_sent;
  int mismatches;
  int stall_cycles;

  header_length_checksum_packet_receiver dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("[%0t] %s: got %0h, want %0h", $realtime, what, got, want);
  endtask

  // fills sticky error and line bits from the current model state
  function automatic rx_result_t mk_word(logic kind, ev_t ev, logic [7:0] cmd,
                                         logic [LEN_W-1:0] len, logic [7:0] data,
                                         logic [ADDR_W-1:0] idx, logic last, logic valid);
    rx_result_t w;
    w.kind      = kind;
    w.ev        = ev;
    w.err       = sticky;
    w.line_bits = line_bits;
    w.cmd       = cmd;
    w.len       = len;
    w.data      = data;
    w.idx       = idx;
    w.last      = last;
    w.valid     = valid;
    return w;
  endfunction

  // advances the parser model by one input word, results go to burst
  function automatic int parse_item(logic op, logic [7:0] b, logic [2:0] lerr);
    ev_t ev;
    int  n;
    ev = EV_NONE;
    // readout of the held packet, or a single empty word
    if (op == OP_RELEASE) begin
      if (!pkt_held) begin
        burst[0] = mk_word(KIND_READOUT, EV_NONE, '0, '0, '0, '0, 1'b1, 1'b0);
        return 1;
      end
      pkt_held = 1'b0;
      n = (pkt_len == 0) ? 1 : int'(pkt_len);
      for (int k = 0; k < n; k++)
        burst[k] = mk_word(KIND_READOUT, EV_NONE, pkt_cmd, pkt_len[LEN_W-1:0],
                           (pkt_len == 0) ? 8'h00 : pkt_bytes[k], k[ADDR_W-1:0],
                           k == n - 1, 1'b1);
      return n;
    end
    // line byte
    if (pkt_held) begin
      ev = EV_DROPPED;
    end else if (lerr != 0) begin
      sticky    = ERR_LINE;
      line_bits = lerr;
      frame_pos = 0;
      frame_sum = 8'h00;
      ev        = EV_LINE;
    end else begin
      case (frame_pos)
        0: begin
          if (b == hdr_first) begin
            frame_sum = b;
            frame_pos = 1;
          end
        end
        1: begin
          if (b == hdr_second) begin
            frame_sum += b;
            frame_pos = 2;
          end else begin
            frame_sum = 8'h00;
            frame_pos = 0;
          end
        end
        2: begin
          pkt_cmd   = b;
          frame_sum += b;
          frame_pos = 3;
        end
        3: begin
          if (b > MAX_PAYLOAD) begin
            sticky    = ERR_OVERRUN;
            frame_sum = 8'h00;
            frame_pos = 0;
            ev        = EV_OVERRUN;
          end else begin
            pkt_len   = b;
            frame_sum += b;
            frame_pos = 4;
          end
        end
        default: begin
          // checksum position, else a payload byte
          if (frame_pos == pkt_len + PAY_OFFSET) begin
            if (b == frame_sum) begin
              pkt_held = 1'b1;
              ev       = EV_COMPLETE;
            end else begin
              sticky = ERR_CHECKSUM;
              ev     = EV_CHECKSUM;
            end
            frame_sum = 8'h00;
            frame_pos = 0;
          end else begin
            pkt_bytes[frame_pos - PAY_OFFSET] = b;
            frame_sum += b;
            frame_pos++;
          end
        end
      endcase
    end
    burst[0] = mk_word(KIND_STATUS, ev, '0, '0, '0, '0, 1'b0, 1'b0);
    return 1;
  endfunction

  // offers one input word after a random gap and waits for it to be taken
  task automatic drive_word(logic op, logic [7:0] b, logic [2:0] lerr,
                            logic typed = 1'b0, ev_t tev = EV_NONE, err_t terr = ERR_NONE);
    int n;
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, lerr, b};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    n = parse_item(op, b, lerr);
    if (typed) begin
      burst[0].ev  = tev;
      burst[0].err = terr;
    end
    for (int k = 0; k < n; k++)
      expected_words.push_back(burst[k]);
    items_sent++;
  endtask

  // sender goes quiet until every expected word is out
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
  endtask

  // writes both header registers back to back, block idle
  task automatic set_headers(logic [7:0] first, logic [7:0] second);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HEADER_FIRST;
    cfg_wdata <= first;
    @(posedge clk);
    hdr_first = first;
    @(negedge clk);
    cfg_index <= REG_HEADER_SECOND;
    cfg_wdata <= second;
    @(posedge clk);
    hdr_second = second;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // one packet; a length given by the caller means a clean packet
  task automatic send_packet(int len_req);
    logic [7:0] pkt [$];
    logic [7:0] len;
    logic [7:0] sum;
    int         pick;
    int         cut;
    sum  = 8'h00;
    pick = $urandom_range(99);
    if (len_req >= 0) len = 8'(len_req);
    else if (pick < 6) len = 8'(MAX_PAYLOAD);
    else if (pick < 12) len = 8'($urandom_range(255, MAX_PAYLOAD + 1));
    else if (pick < 22) len = 8'h00;
    else len = 8'($urandom_range(8, 1));
    pkt.push_back(hdr_first);
    if (len_req < 0 && $urandom_range(99) < 5)
      pkt.push_back(hdr_second ^ 8'($urandom_range(255, 1)));
    else
      pkt.push_back(hdr_second);
    pkt.push_back(8'($urandom()));
    pkt.push_back(len);
    // overrun packets stop at the length byte
    if (len <= MAX_PAYLOAD) begin
      repeat (len) pkt.push_back(8'($urandom()));
      foreach (pkt[i]) sum += pkt[i];
      if (len_req < 0 && $urandom_range(99) < 12) sum ^= 8'($urandom_range(255, 1));
      pkt.push_back(sum);
    end
    // now and then a line error cuts the packet short
    cut = (len_req < 0 && $urandom_range(99) < 8) ? $urandom_range(pkt.size() - 1) : -1;
    foreach (pkt[i]) begin
      if (i == cut) begin
        drive_word(OP_BYTE, pkt[i], 3'($urandom_range(7, 1)));
        break;
      end
      drive_word(OP_BYTE, pkt[i], 3'd0);
    end
  endtask

  // mostly packets with a release, some bytes while held, some line noise
  task automatic random_traffic(int target);
    int pick;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_packet(-1);
        if ($urandom_range(99) < 15)
          repeat ($urandom_range(3, 1)) drive_word(OP_BYTE, 8'($urandom()), 3'($urandom()));
        if ($urandom_range(99) < 85)
          drive_word(OP_RELEASE, 8'($urandom()), 3'($urandom()));
      end else if (pick < 80) begin
        drive_word(OP_RELEASE, 8'($urandom()), 3'($urandom()));
      end else begin
        drive_word(OP_BYTE, 8'($urandom()),
                   ($urandom_range(99) < 30) ? 3'($urandom_range(7, 1)) : 3'd0);
      end
    end
  endtask

  // receiver ready, with an occasional long hold-off
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        sink_hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_stall);
      end
    end
  end

  // result check against the oldest expected word
  always @(posedge clk) begin
    rx_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result word with none pending", m_tdata, 0);
      end else begin
        want = expected_words.pop_front();
        if (m_tuser[0] !== want.kind)      report_mismatch("result_kind", m_tuser[0], want.kind);
        if (m_tdata[2:0] !== want.ev)      report_mismatch("event_code", m_tdata[2:0], want.ev);
        if (m_tdata[4:3] !== want.err)     report_mismatch("last_error", m_tdata[4:3], want.err);
        if (m_tdata[7:5] !== want.line_bits)
          report_mismatch("last_line_bits", m_tdata[7:5], want.line_bits);
        if (m_tdata[15:8] !== want.cmd)    report_mismatch("command", m_tdata[15:8], want.cmd);
        if (m_tdata[21:16] !== want.len)
          report_mismatch("payload_length", m_tdata[21:16], want.len);
        if (m_tdata[29:22] !== want.data)  report_mismatch("data_byte", m_tdata[29:22], want.data);
        if (m_tdata[34:30] !== want.idx)   report_mismatch("byte_index", m_tdata[34:30], want.idx);
        if (m_tlast !== want.last)         report_mismatch("last", m_tlast, want.last);
        if (m_tuser[1] !== want.valid)     report_mismatch("payload_valid", m_tuser[1], want.valid);
      end
    end
  end

  // watchdog on cycles with no word moving on either stream
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // main sequence
  initial begin
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_HEADER_FIRST;
    cfg_wdata    <= 8'h00;
    s_tvalid     <= 1'b0;
    s_tdata      <= 16'h0000;
    s_tuser      <= OP_BYTE;
    src_idle     = 0;
    sink_stall   = 0;
    sink_hold    = 0;
    items_sent   = 0;
    mismatches   = 0;
    hdr_first    = 8'hAA;
    hdr_second   = 8'h55;
    frame_pos    = 0;
    frame_sum    = 8'h00;
    pkt_held     = 1'b0;
    pkt_cmd      = 8'h00;
    pkt_len      = 8'h00;
    sticky       = ERR_NONE;
    line_bits    = 3'd0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners, then a full-size packet and its readout
    foreach (DIRECTED_ITEMS[i])
      drive_word(DIRECTED_ITEMS[i].op, DIRECTED_ITEMS[i].rx, DIRECTED_ITEMS[i].lerr,
                 DIRECTED_ITEMS[i].typed, DIRECTED_ITEMS[i].ev, DIRECTED_ITEMS[i].err);
    send_packet(MAX_PAYLOAD);
    drive_word(OP_RELEASE, 8'h00, 3'd0);

    // extreme headers, no idling
    wait_drained();
    set_headers(8'h00, 8'hFF);
    random_traffic(110);

    // sender mostly idle
    wait_drained();
    set_headers(8'hFF, 8'h00);
    src_idle = 84;
    random_traffic(190);

    // receiver mostly stalled
    wait_drained();
    set_headers(8'($urandom()), 8'($urandom()));
    src_idle   = 0;
    sink_stall = 84;
    random_traffic(270);

    // equal header bytes, both sides idling
    wait_drained();
    set_headers(8'h5A, 8'h5A);
    src_idle   = 24;
    sink_stall = 24;
    random_traffic(350);

    // long receiver hold-off while the sender keeps offering
    wait_drained();
    set_headers(8'hAA, 8'h55);
    src_idle   = 0;
    sink_stall = 0;
    sink_hold  = 300;
    random_traffic(390);

    // sender pauses for a full drain, then more traffic
    wait_drained();
    sink_stall = 24;
    random_traffic(450);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== header_length_checksum_packet_receiver.f =====
+incdir+sv
sv/hlcpr_pkg.sv
sv/hlcpr_parser.sv
sv/hlcpr_emitter.sv
sv/header_length_checksum_packet_receiver.sv
dv/tb_header_length_checksum_packet_receiver.sv
